[hdl/rced_pkg.sv]
// Package of the Robinson compass edge detector: sizes, mask table, shared types.
// Used by every module of the block; depends on nothing else.
`default_nettype none
package rced_pkg;

  localparam int MAX_LINE   = 1024;
  localparam int PIXEL_BITS = 8;

  localparam int ADDR_W     = $clog2(MAX_LINE);
  localparam int LEN_CFG_W  = 11;
  localparam int TOT_W      = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CMP_W      = (ADDR_W + 1 > LEN_CFG_W) ? ADDR_W + 1 : LEN_CFG_W;
  localparam int MAG_W      = PIXEL_BITS + 2;
  localparam int ACC_W      = PIXEL_BITS + 4;
  localparam int DIR_W      = 3;
  localparam int NUM_MASKS  = 8;

  localparam int FIFO_DEPTH = 32;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int RES_W      = FIFO_AW + 1;

  // Configuration register indexes.
  localparam logic REG_LINE_LENGTH = 1'b0;
  localparam logic REG_LINE_TOTAL  = 1'b1;

  // Compass masks, row major: element y*3+x, row 0 is the line above.
  localparam int COMPASS [NUM_MASKS][9] = '{
    '{-1,  0,  1, -2,  0,  2, -1,  0,  1},
    '{ 0,  1,  2, -1,  0,  1, -2, -1,  0},
    '{ 1,  2,  1,  0,  0,  0, -1, -2, -1},
    '{ 2,  1,  0,  1,  0, -1,  0, -1, -2},
    '{ 1,  0, -1,  2,  0, -2,  1,  0, -1},
    '{ 0, -1, -2,  1,  0, -1,  2,  1,  0},
    '{-1, -2, -1,  0,  0,  0,  1,  2,  1},
    '{-2, -1,  0, -1,  0,  1,  0,  1,  2}
  };

  typedef logic [PIXEL_BITS-1:0] pix_t;
  typedef pix_t [8:0] nbhd_t;

  // One result slot travelling down the cell row.
  typedef struct packed {
    logic             vld;
    nbhd_t            nb;
    logic             fend;
    logic             last;
    logic [MAG_W-1:0] best;
    logic [DIR_W-1:0] dir;
  } lane_t;

  // Slot 0 is delivered before slot 1.
  typedef lane_t [1:0] lpair_t;

  // Control handed from the accept stage to the window stage.
  typedef struct packed {
    logic              vld;
    logic              drn;
    pix_t              pval;
    logic              rlow;
    logic              c0;
    logic              c1;
    logic              emit_a;
    logic              emit_b;
    logic              last_a;
    logic              dfirst;
    logic              top_prev;
    logic              fend;
    logic [ADDR_W-1:0] waddr;
  } s1_ctrl_t;

  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic [DIR_W-1:0] dir;
    logic             no_edge;
    logic             fend;
    logic             last;
  } res_t;

  function automatic res_t lane_to_res(input lane_t l);
    res_t r;
    r.no_edge = (l.best == '0);
    r.mag     = r.no_edge ? MAG_W'(l.nb[4]) : l.best;
    r.dir     = r.no_edge ? '0 : l.dir;
    r.fend    = l.fend;
    r.last    = l.last;
    return r;
  endfunction

endpackage
`default_nettype wire

[hdl/rced_cell.sv]
// One cell of the compass row: applies one mask to both slots and keeps the running maximum.
// Depends on rced_pkg.
`default_nettype none
module rced_cell import rced_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [DIR_W-1:0] mask_idx,
  input  lpair_t           in_i,
  output lpair_t           out_o
);

  lpair_t out_r, out_nxt;

  always_comb begin
    logic signed [ACC_W-1:0] acc;
    out_nxt = in_i;
    for (int l = 0; l < 2; l++) begin
      acc = '0;
      for (int i = 0; i < 9; i++) begin
        acc = acc + ACC_W'(COMPASS[mask_idx][i])
                    * $signed({{(ACC_W-PIXEL_BITS){1'b0}}, in_i[l].nb[i]});
      end
      // Strictly greater keeps the first mask that reaches the maximum.
      if (acc > $signed({{(ACC_W-MAG_W){1'b0}}, in_i[l].best})) begin
        out_nxt[l].best = acc[MAG_W-1:0];
        out_nxt[l].dir  = mask_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r[0].vld <= 1'b0;
      out_r[1].vld <= 1'b0;
    end else begin
      out_r <= out_nxt;
    end
  end

  assign out_o = out_r;

endmodule
`default_nettype wire

[hdl/rced_window.sv]
// 3x3 window with edge replication; builds up to two neighborhoods per beat.
// Depends on rced_pkg.
`default_nettype none
module rced_window import rced_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  s1_ctrl_t ctl_i,
  input  pix_t     prev_rd_i,
  input  pix_t     older_rd_i,
  output lpair_t   lanes_o
);

  pix_t [2:0][2:0] w_r, w_nxt;  // [row][column], column 2 is the newest
  pix_t            cap_old_r, cap_prev_r;
  lpair_t          lanes_r, lanes_nxt;

  function automatic nbhd_t build(input pix_t [2:0][2:0] w, input logic [1:0] lc,
                                  input logic [1:0] cc, input logic [1:0] rc);
    nbhd_t nb;
    for (int y = 0; y < 3; y++) begin
      nb[y*3]     = w[y][lc];
      nb[y*3 + 1] = w[y][cc];
      nb[y*3 + 2] = w[y][rc];
    end
    return nb;
  endfunction

  always_comb begin
    pix_t [2:0] ncol;
    pix_t [2:0] ccol;
    w_nxt = w_r;
    ncol  = '0;
    ccol  = '0;
    if (ctl_i.vld && !ctl_i.drn) begin
      ncol[0] = ctl_i.rlow ? prev_rd_i : older_rd_i;
      ncol[1] = prev_rd_i;
      ncol[2] = ctl_i.pval;
      for (int r = 0; r < 3; r++) begin
        w_nxt[r][0] = w_r[r][1];
        w_nxt[r][1] = w_r[r][2];
        w_nxt[r][2] = ncol[r];
      end
    end else if (ctl_i.vld) begin
      // Drain: the bottom row replicates the last line.
      ncol[0] = ctl_i.top_prev ? prev_rd_i : older_rd_i;
      ncol[1] = prev_rd_i;
      ncol[2] = prev_rd_i;
      ccol[0] = ctl_i.top_prev ? cap_prev_r : cap_old_r;
      ccol[1] = cap_prev_r;
      ccol[2] = cap_prev_r;
      for (int r = 0; r < 3; r++) begin
        if (ctl_i.dfirst) begin
          w_nxt[r][0] = ccol[r];
          w_nxt[r][1] = ccol[r];
        end else begin
          w_nxt[r][0] = w_r[r][1];
          w_nxt[r][1] = w_r[r][2];
        end
        w_nxt[r][2] = ncol[r];
      end
    end

    lanes_nxt = '0;
    lanes_nxt[0].vld  = ctl_i.vld && (ctl_i.drn || ctl_i.emit_a);
    lanes_nxt[0].nb   = build(w_nxt, (!ctl_i.drn && ctl_i.c1) ? 2'd1 : 2'd0, 2'd1, 2'd2);
    lanes_nxt[0].fend = ctl_i.drn && ctl_i.fend;
    lanes_nxt[0].last = ctl_i.drn || ctl_i.last_a;
    lanes_nxt[1].vld  = ctl_i.vld && !ctl_i.drn && ctl_i.emit_b;
    lanes_nxt[1].nb   = build(w_nxt, ctl_i.c0 ? 2'd2 : 2'd1, 2'd2, 2'd2);
    lanes_nxt[1].fend = 1'b0;
    lanes_nxt[1].last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r          <= '0;
      lanes_r[0].vld <= 1'b0;
      lanes_r[1].vld <= 1'b0;
    end else begin
      w_r     <= w_nxt;
      lanes_r <= lanes_nxt;
    end
  end

  // Column 0 of each line is kept for the first drain neighborhood.
  always_ff @(posedge clk) begin
    if (ctl_i.vld && !ctl_i.drn && ctl_i.c0) begin
      cap_old_r  <= prev_rd_i;
      cap_prev_r <= ctl_i.pval;
    end
  end

  assign lanes_o = lanes_r;

endmodule
`default_nettype wire

[hdl/rced_fifo.sv]
// Result queue: takes up to two results per cycle, gives one per beat.
// Depends on rced_pkg.
`default_nettype none
module rced_fifo import rced_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  lpair_t push_i,
  input  logic   pop_i,
  output logic   vld_o,
  output res_t   head_o
);

  res_t               mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wp_r, rp_r, wp_nxt, rp_nxt, wp2;
  logic [RES_W-1:0]   cnt_r, cnt_nxt;

  always_comb begin
    wp2     = wp_r + FIFO_AW'(push_i[0].vld);
    wp_nxt  = wp_r + FIFO_AW'(push_i[0].vld) + FIFO_AW'(push_i[1].vld);
    rp_nxt  = rp_r + FIFO_AW'(pop_i);
    cnt_nxt = cnt_r + RES_W'(push_i[0].vld) + RES_W'(push_i[1].vld) - RES_W'(pop_i);
  end

  always_ff @(posedge clk) begin
    if (push_i[0].vld) mem_r[wp_r] <= lane_to_res(push_i[0]);
    if (push_i[1].vld) mem_r[wp2]  <= lane_to_res(push_i[1]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign vld_o  = (cnt_r != '0);
  assign head_o = mem_r[rp_r];

endmodule
`default_nettype wire

[hdl/robinson_compass_edge_detector_unit.sv]
// Robinson compass edge detector, top level: line stores, scan control, cell row, result queue.
// Depends on rced_pkg, rced_window, rced_cell and rced_fifo.
//
// Takes one pixel or drain tick per clock while in_ready is high. Each beat is registered
// into two line stores (one read port each, read data registered), then into a 3x3 window,
// then down a row of eight cells, one compass mask per cell, and then into the result queue.
// The first pixel of a line gives no result and the last gives two, so each line after the
// first yields as many results as it has pixels, the drain giving those of the last line,
// and a steady stream with a ready receiver is never held. in_ready falls only when the
// 32-entry result queue could not take a further beat's results on top of those reserved,
// that is when the receiver stalls. The line stores need no clearing pass after reset.
`default_nettype none
module robinson_compass_edge_detector_unit import rced_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_mode,
  input  logic [PIXEL_BITS-1:0] in_pixel_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [MAG_W-1:0]      out_magnitude,
  output logic [DIR_W-1:0]      out_direction,
  output logic                  out_no_edge,
  output logic                  out_frame_end,
  output logic                  out_last_in_step,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [LEN_CFG_W-1:0] len_cfg_r;
  logic [TOT_W-1:0]     tot_cfg_r;
  logic [ADDR_W-1:0]    inner_r, inner_nxt;
  logic [TOT_W-1:0]     outer_r, outer_nxt;
  logic [CMP_W-1:0]     drain_r, drain_nxt;
  logic                 fc_r, fc_nxt;
  s1_ctrl_t             s1_r, s1_nxt;
  logic [RES_W-1:0]     res_r, res_nxt;

  pix_t                 prev_mem [MAX_LINE];
  pix_t                 older_mem [MAX_LINE];
  pix_t                 prev_rd_r, older_rd_r, fwd_val_r, older_eff;
  logic                 fwd_hit_r;

  logic [CMP_W-1:0]     eff_len, c_ext, k_inc;
  logic [TOT_W-1:0]     eff_tot;
  logic                 endrow, r_last, k_in, k_end, in_acc, out_acc, pix_go;
  logic [ADDR_W-1:0]    drain_addr, rd_addr;
  logic [1:0]           n_res;
  lpair_t               chain [NUM_MASKS + 1];
  res_t                 head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_cfg_r <= LEN_CFG_W'(640);
      tot_cfg_r <= TOT_W'(480);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_LINE_LENGTH: len_cfg_r <= cfg_data[LEN_CFG_W-1:0];
        REG_LINE_TOTAL:  tot_cfg_r <= cfg_data[TOT_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;
  assign in_ready = (res_r <= RES_W'(FIFO_DEPTH - 2));

  always_comb begin
    if (len_cfg_r == '0) begin
      eff_len = CMP_W'(1);
    end else if (CMP_W'(len_cfg_r) > CMP_W'(MAX_LINE)) begin
      eff_len = CMP_W'(MAX_LINE);
    end else begin
      eff_len = CMP_W'(len_cfg_r);
    end
    eff_tot    = (tot_cfg_r == '0) ? TOT_W'(1) : tot_cfg_r;
    c_ext      = CMP_W'(inner_r);
    endrow     = (c_ext + CMP_W'(1)) >= eff_len;
    r_last     = ({1'b0, outer_r} + (TOT_W+1)'(1)) >= {1'b0, eff_tot};
    k_inc      = drain_r + CMP_W'(1);
    k_in       = drain_r < eff_len;
    k_end      = k_inc >= eff_len;
    drain_addr = k_end ? ADDR_W'(eff_len - CMP_W'(1)) : ADDR_W'(k_inc);
    rd_addr    = in_mode ? drain_addr : inner_r;
    pix_go     = !in_mode && !fc_r;

    n_res = 2'd0;
    if (pix_go && outer_r != '0) begin
      n_res = 2'((inner_r != '0)) + 2'(endrow);
    end else if (in_mode && fc_r && k_in) begin
      n_res = 2'd1;
    end

    s1_nxt.vld      = in_acc && (pix_go || (in_mode && fc_r && k_in));
    s1_nxt.drn      = in_mode;
    s1_nxt.pval     = in_pixel_value;
    s1_nxt.rlow     = (outer_r <= TOT_W'(1));
    s1_nxt.c0       = (inner_r == '0);
    s1_nxt.c1       = (inner_r == ADDR_W'(1));
    s1_nxt.emit_a   = (outer_r != '0) && (inner_r != '0);
    s1_nxt.emit_b   = (outer_r != '0) && endrow;
    s1_nxt.last_a   = !endrow;
    s1_nxt.dfirst   = (drain_r == '0);
    s1_nxt.top_prev = (outer_r == '0);
    s1_nxt.fend     = k_end;
    s1_nxt.waddr    = inner_r;

    inner_nxt = inner_r;
    outer_nxt = outer_r;
    drain_nxt = drain_r;
    fc_nxt    = fc_r;
    if (in_acc && pix_go) begin
      if (endrow) begin
        inner_nxt = '0;
        if (r_last) begin
          fc_nxt    = 1'b1;
          drain_nxt = '0;
        end else begin
          outer_nxt = outer_r + TOT_W'(1);
        end
      end else begin
        inner_nxt = inner_r + ADDR_W'(1);
      end
    end else if (in_acc && in_mode && fc_r) begin
      if (!k_in || k_end) begin
        fc_nxt    = 1'b0;
        drain_nxt = '0;
        inner_nxt = '0;
        outer_nxt = '0;
      end else begin
        drain_nxt = k_inc;
      end
    end

    res_nxt = res_r + RES_W'(in_acc ? n_res : 2'd0) - RES_W'(out_acc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inner_r <= '0;
      outer_r <= '0;
      drain_r <= '0;
      fc_r    <= 1'b0;
      s1_r    <= '0;
      res_r   <= '0;
    end else begin
      inner_r <= inner_nxt;
      outer_r <= outer_nxt;
      drain_r <= drain_nxt;
      fc_r    <= fc_nxt;
      s1_r    <= s1_nxt;
      res_r   <= res_nxt;
    end
  end

  // The older store takes the previous-line value from its registered read, a stage late,
  // so a read of the same entry in the cycle it is written (single-pixel lines) is forwarded.
  always_ff @(posedge clk) begin
    if (in_acc && pix_go) prev_mem[inner_r] <= in_pixel_value;
    prev_rd_r <= prev_mem[rd_addr];
    if (s1_r.vld && !s1_r.drn) older_mem[s1_r.waddr] <= prev_rd_r;
    older_rd_r <= older_mem[rd_addr];
    fwd_hit_r  <= s1_r.vld && !s1_r.drn && (s1_r.waddr == rd_addr);
    fwd_val_r  <= prev_rd_r;
  end

  assign older_eff = fwd_hit_r ? fwd_val_r : older_rd_r;

  rced_window u_window (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl_i      (s1_r),
    .prev_rd_i  (prev_rd_r),
    .older_rd_i (older_eff),
    .lanes_o    (chain[0])
  );

  for (genvar k = 0; k < NUM_MASKS; k++) begin : g_cell
    rced_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .mask_idx (DIR_W'(k)),
      .in_i     (chain[k]),
      .out_o    (chain[k+1])
    );
  end

  rced_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_i (chain[NUM_MASKS]),
    .pop_i  (out_acc),
    .vld_o  (out_valid),
    .head_o (head)
  );

  assign out_magnitude    = head.mag;
  assign out_direction    = head.dir;
  assign out_no_edge      = head.no_edge;
  assign out_frame_end    = head.fend;
  assign out_last_in_step = head.last;

  // Reservations never exceed the queue, so an accepted beat always finds room.
  a_res_bound: assert property (@(posedge clk) disable iff (!rst_n)
    res_r <= RES_W'(FIFO_DEPTH)) else $error("result reservations exceed queue depth");

  a_res_cover: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> res_r != '0) else $error("queued result without a reservation");

  a_drain_frame: assert property (@(posedge clk) disable iff (!rst_n)
    s1_r.vld && s1_r.drn |-> $past(fc_r)) else $error("drain beat outside a finished frame");

  a_pixel_flow: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && pix_go |=> s1_r.vld && !s1_r.drn) else $error("accepted pixel lost");

endmodule
`default_nettype wire

[tb/tb_robinson_compass_edge_detector_unit.sv]
// Testbench of the Robinson compass edge detector: directed frames, then random frames.
// Depends on rced_pkg and robinson_compass_edge_detector_unit; a local predictor checks results.
`timescale 1ns / 100ps
module tb_robinson_compass_edge_detector_unit;
  import rced_pkg::*;

  typedef struct {
    logic       mode;
    logic [7:0] pix;
  } beat_t;

  typedef struct {
    logic [9:0] mag;
    logic [2:0] dir;
    logic       no_edge;
    logic       fend;
    logic       last;
  } edge_res_t;

  typedef int nbhd3_t [3][3];

  localparam int DEPTH = 1024;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE = 24;

  // Compass masks, row 0 is the line above, column 0 the pixel to the left.
  localparam int MASK [8][9] = '{
    '{-1, 0, 1, -2, 0, 2, -1, 0, 1},
    '{ 0, 1, 2, -1, 0, 1, -2, -1, 0},
    '{ 1, 2, 1, 0, 0, 0, -1, -2, -1},
    '{ 2, 1, 0, 1, 0, -1, 0, -1, -2},
    '{ 1, 0, -1, 2, 0, -2, 1, 0, -1},
    '{ 0, -1, -2, 1, 0, -1, 2, 1, 0},
    '{-1, -2, -1, 0, 0, 0, 1, 2, 1},
    '{-2, -1, 0, -1, 0, 1, 0, 1, 2}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_mode = 1'b0;
  logic [PIXEL_BITS-1:0] in_pixel_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [MAG_W-1:0] out_magnitude;
  logic [DIR_W-1:0] out_direction;
  logic out_no_edge, out_frame_end, out_last_in_step;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = REG_LINE_LENGTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  robinson_compass_edge_detector_unit DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state.
  logic [10:0] len_reg = 11'd640;
  logic [15:0] total_reg = 16'd480;
  logic [7:0] older_line [DEPTH];
  logic [7:0] prev_line [DEPTH];
  logic [7:0] win [3][3];
  int col_pos, row_pos, drain_pos;
  bit frame_done;

  beat_t pending_beats[$];
  edge_res_t expected_results[$];
  int send_idle_pct, recv_idle_pct;
  bit hold_in;
  int errors, pixels_sent, drains_sent, results_seen, frames_run, quiet_cycles;

  function automatic int eff_len();
    if (len_reg == 0) return 1;
    if (len_reg > DEPTH) return DEPTH;
    return len_reg;
  endfunction

  function automatic int eff_total();
    return (total_reg == 0) ? 1 : total_reg;
  endfunction

  task automatic push_edge(input nbhd3_t nb, input bit fend, input bit last);
    int best, dir, acc;
    edge_res_t r;
    best = 0;
    dir = 0;
    for (int k = 0; k < 8; k++) begin
      acc = 0;
      for (int i = 0; i < 9; i++) acc += nb[i / 3][i % 3] * MASK[k][i];
      if (acc > best) begin
        best = acc;
        dir = k;
      end
    end
    r.no_edge = (best == 0);
    r.mag = r.no_edge ? 10'(nb[1][1]) : 10'(best);
    r.dir = r.no_edge ? 3'd0 : 3'(dir);
    r.fend = fend;
    r.last = last;
    expected_results.push_back(r);
  endtask

  task automatic from_win(output nbhd3_t nb, input int lc, input int cc, input int rc);
    for (int y = 0; y < 3; y++) begin
      nb[y][0] = win[y][lc];
      nb[y][1] = win[y][cc];
      nb[y][2] = win[y][rc];
    end
  endtask

  task automatic predict_edges(input beat_t b);
    int len, c, r, x;
    nbhd3_t nb;
    logic [7:0] top, mid;
    bit endrow;
    len = eff_len();
    if (b.mode) begin
      if (!frame_done) return;
      if (drain_pos >= len) begin
        frame_done = 0;
        col_pos = 0; row_pos = 0; drain_pos = 0;
        return;
      end
      for (int d = 0; d < 3; d++) begin
        if (d == 0) x = (drain_pos == 0) ? 0 : drain_pos - 1;
        else if (d == 1) x = drain_pos;
        else x = (drain_pos + 1 >= len) ? len - 1 : drain_pos + 1;
        nb[0][d] = (row_pos == 0) ? prev_line[x] : older_line[x];
        nb[1][d] = prev_line[x];
        nb[2][d] = prev_line[x];
      end
      push_edge(nb, drain_pos + 1 >= len, 1'b1);
      drain_pos++;
      if (drain_pos >= len) begin
        frame_done = 0;
        col_pos = 0; row_pos = 0; drain_pos = 0;
      end
    end else begin
      if (frame_done) return;
      c = (col_pos >= DEPTH) ? DEPTH - 1 : col_pos;
      r = row_pos;
      mid = prev_line[c];
      top = (r <= 1) ? mid : older_line[c];
      for (int y = 0; y < 3; y++) begin
        win[y][0] = win[y][1];
        win[y][1] = win[y][2];
      end
      win[0][2] = top;
      win[1][2] = mid;
      win[2][2] = b.pix;
      older_line[c] = mid;
      prev_line[c] = b.pix;
      endrow = (c + 1 >= len);
      if (r >= 1) begin
        if (c >= 1) begin
          from_win(nb, (c == 1) ? 1 : 0, 1, 2);
          push_edge(nb, 1'b0, !endrow);
        end
        if (endrow) begin
          from_win(nb, (c == 0) ? 2 : 1, 2, 2);
          push_edge(nb, 1'b0, 1'b1);
        end
      end
      if (endrow) begin
        col_pos = 0;
        if (r + 1 >= eff_total()) begin
          frame_done = 1;
          drain_pos = 0;
        end else begin
          row_pos = (r + 1) & 16'hFFFF;
        end
      end else begin
        col_pos = c + 1;
      end
    end
  endtask

  // Driver: predicts each beat as it is accepted, then offers the next one.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_edges('{in_mode, in_pixel_value});
        if (in_mode) drains_sent++;
        else pixels_sent++;
      end
      if (!in_valid || in_ready) begin
        if (pending_beats.size() > 0 && !hold_in && $urandom_range(99) >= send_idle_pct) begin
          beat_t b;
          b = pending_beats.pop_front();
          in_valid <= 1'b1;
          in_mode <= b.mode;
          in_pixel_value <= b.pix;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares every accepted result beat with the oldest prediction.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result beat mag=%0d dir=%0d", $time, out_magnitude,
                   out_direction);
        end else begin
          edge_res_t e;
          e = expected_results.pop_front();
          if (e.mag !== out_magnitude || e.dir !== out_direction ||
              e.no_edge !== out_no_edge || e.fend !== out_frame_end ||
              e.last !== out_last_in_step) begin
            errors++;
            $display("%0t: mismatch expected mag=%0d dir=%0d ne=%0b fe=%0b last=%0b",
                     $time, e.mag, e.dir, e.no_edge, e.fend, e.last);
            $display("%0t:          actual mag=%0d dir=%0d ne=%0b fe=%0b last=%0b",
                     $time, out_magnitude, out_direction, out_no_edge, out_frame_end,
                     out_last_in_step);
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired with %0d results outstanding", $time,
                 expected_results.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic wait_idle();
    while (pending_beats.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_LINE_LENGTH) len_reg = val[10:0];
    else total_reg = val;
  endtask

  task automatic queue_pixel(input logic [7:0] p);
    pending_beats.push_back('{1'b0, p});
  endtask

  task automatic queue_drains(input int n);
    for (int i = 0; i < n; i++) pending_beats.push_back('{1'b1, 8'd0});
  endtask

  // A whole frame and its drain under the current settings, with random or patterned content and some noise.
  task automatic queue_frame(input int style);
    int len, tot;
    logic [7:0] p;
    len = eff_len();
    tot = eff_total();
    for (int r = 0; r < tot; r++) begin
      for (int c = 0; c < len; c++) begin
        case (style)
          0: p = 8'($urandom_range(255));
          1: p = ($urandom_range(1)) ? 8'hFF : 8'h00;
          2: p = ((c + r) % 4 < 2) ? 8'd255 : 8'd0;
          default: p = 8'($urandom_range(20) + 100);
        endcase
        queue_pixel(p);
        // Stray drain before the frame is complete is ignored.
        if ((r < tot - 1 || c < len - 1) && $urandom_range(99) < 3) queue_drains(1);
      end
    end
    for (int i = 0; i < len; i++) begin
      queue_drains(1);
      // Stray pixel while draining is ignored.
      if (i < len - 1 && $urandom_range(99) < 3) queue_pixel(8'($urandom_range(255)));
    end
    frames_run++;
  endtask

  initial begin
    int lens [4];
    send_idle_pct = 12;
    recv_idle_pct = 56;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Drain with no frame pending gives nothing.
    queue_drains(2);
    write_reg(REG_LINE_LENGTH, 16'd4);
    write_reg(REG_LINE_TOTAL, 16'd3);
    for (int i = 0; i < 12; i++) queue_pixel((i % 3 == 0) ? 8'd255 : 8'd0);
    queue_drains(2);
    queue_pixel(8'd77);
    queue_drains(3);
    // Single-line frame, and length zero acting as one.
    write_reg(REG_LINE_TOTAL, 16'd1);
    queue_frame(0);
    write_reg(REG_LINE_LENGTH, 16'd0);
    write_reg(REG_LINE_TOTAL, 16'd0);
    queue_frame(1);
    // Largest total, then shortened mid-frame.
    write_reg(REG_LINE_LENGTH, 16'd1);
    write_reg(REG_LINE_TOTAL, 16'hFFFF);
    for (int i = 0; i < 5; i++) queue_pixel(8'(i * 60));
    write_reg(REG_LINE_TOTAL, 16'd3);
    queue_pixel(8'd255);
    queue_drains(2);
    // Length shrunk mid-line ends that line at once.
    write_reg(REG_LINE_LENGTH, 16'd6);
    for (int i = 0; i < 9; i++) queue_pixel(8'($urandom_range(255)));
    write_reg(REG_LINE_LENGTH, 16'd2);
    for (int i = 0; i < 3; i++) queue_pixel(8'($urandom_range(255)));
    queue_drains(3);
    // Length field overflowing past the store size clamps to its size; the second
    // line is then shortened to keep the frame small.
    write_reg(REG_LINE_LENGTH, 16'hFFFF);
    write_reg(REG_LINE_TOTAL, 16'd2);
    for (int i = 0; i < DEPTH; i++) queue_pixel(8'($urandom_range(255)));
    write_reg(REG_LINE_LENGTH, 16'd3);
    for (int i = 0; i < 3; i++) queue_pixel(8'($urandom_range(255)));
    queue_drains(3);

    lens = '{1, 2, 3, 8};
    while (pixels_sent < 1700) begin
      if (pixels_sent > 1250 && send_idle_pct == 12) begin
        send_idle_pct = 56;
        recv_idle_pct = 12;
      end else if (pixels_sent > 1450 && send_idle_pct == 56) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        // Hold the input until everything in flight has come out.
        hold_in = 1;
        while (expected_results.size() > 0) @(posedge clk);
        hold_in = 0;
      end
      if ($urandom_range(1)) begin
        write_reg(REG_LINE_LENGTH, ($urandom_range(3) == 0) ? 16'(lens[$urandom_range(3)])
                                                            : 16'($urandom_range(12) + 1));
        write_reg(REG_LINE_TOTAL, 16'($urandom_range(5) + 1));
      end
      queue_frame($urandom_range(3));
      while (pending_beats.size() > 40) @(posedge clk);
    end

    wait_idle();
    repeat (40) @(posedge clk);
    $display("Ran %0d frames: %0d pixels and %0d drain beats, %0d result beats checked.",
             frames_run, pixels_sent, drains_sent, results_seen);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d errors, %0d results missing", errors, expected_results.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/rced_pkg.sv
hdl/rced_cell.sv
hdl/rced_window.sv
hdl/rced_fifo.sv
hdl/robinson_compass_edge_detector_unit.sv
tb/tb_robinson_compass_edge_detector_unit.sv
